FILE: rtl/core/tdp_pkg.sv
`timescale 1ns / 1ps

package tdp_pkg;

  // width of the candidate and derived widths
  localparam int VALUE_W = 32;
  // trial factor reaches just past the square root
  localparam int FACT_W  = (VALUE_W + 1) / 2 + 1;
  // running square of the factor, with headroom for the increment
  localparam int SQ_W    = VALUE_W + 2;
  // bit index into the candidate during the remainder pass
  localparam int CNT_W   = $clog2(VALUE_W);

  localparam logic [FACT_W-1:0] FIRST_FACTOR = FACT_W'(2);
  localparam logic [SQ_W-1:0]   FIRST_SQUARE = SQ_W'(4);

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture candidate, reset factor
    logic div_start;  // clear remainder, start bit index at msb
    logic div_step;   // one radix-2 restoring step
    logic adv_factor; // move to next trial factor
    logic mark_comp;  // candidate found composite
    logic emit;       // load the output register
  } tdp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic lt_two;     // candidate below 2
    logic sq_le_n;    // factor squared does not exceed candidate
    logic div_last;   // final remainder step
    logic rem_zero;   // remainder is zero
    logic out_free;   // output register can take a result
  } tdp_stat_t;

endpackage

FILE: rtl/core/tdp_ctrl.sv
`timescale 1ns / 1ps

module tdp_ctrl import tdp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tdp_stat_t stat,
  output tdp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_TEST   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one request at a time, taken only when idle
  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.lt_two || !stat.sq_le_n) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (stat.rem_zero) begin
          cmd.mark_comp = 1'b1;
          state_nxt     = ST_FINISH;
        end else begin
          cmd.adv_factor = 1'b1;
          state_nxt      = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/tdp_datapath.sv
`timescale 1ns / 1ps

module tdp_datapath import tdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [VALUE_W-1:0] in_candidate,
  input  tdp_cmd_t           cmd,
  output tdp_stat_t          stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_tested_value,
  output logic               out_is_prime
);

  logic [VALUE_W-1:0] n_r;
  logic [FACT_W-1:0]  f_r;
  logic [SQ_W-1:0]    sq_r;
  logic [FACT_W-1:0]  rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               comp_r;
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_prime_r;

  logic [FACT_W:0]    shifted;
  logic [FACT_W:0]    diff;
  logic [FACT_W-1:0]  rem_nxt;
  logic [SQ_W-1:0]    sq_nxt;
  logic               verdict;

  // restoring remainder step: bring in next candidate bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, n_r[cnt_r]};
    diff    = shifted - {1'b0, f_r};
    if (shifted >= {1'b0, f_r}) begin
      rem_nxt = diff[FACT_W-1:0];
    end else begin
      rem_nxt = shifted[FACT_W-1:0];
    end
  end

  // (f+1)^2 = f^2 + 2f + 1
  assign sq_nxt = sq_r + SQ_W'({f_r, 1'b1});

  // candidate, factor, square and remainder registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= in_candidate;
      f_r    <= FIRST_FACTOR;
      sq_r   <= FIRST_SQUARE;
      comp_r <= 1'b0;
    end
    if (cmd.adv_factor) begin
      f_r  <= f_r + FACT_W'(1);
      sq_r <= sq_nxt;
    end
    if (cmd.mark_comp) begin
      comp_r <= 1'b1;
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      cnt_r <= CNT_W'(VALUE_W - 1);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // status back to the controller
  assign stat.lt_two   = (n_r < VALUE_W'(2));
  assign stat.sq_le_n  = (sq_r <= SQ_W'(n_r));
  assign stat.div_last = (cnt_r == '0);
  assign stat.rem_zero = (rem_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign verdict = !stat.lt_two && !comp_r;

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= n_r;
      out_prime_r <= verdict;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tested_value = out_value_r;
  assign out_is_prime     = out_prime_r;

endmodule

FILE: rtl/core/trial_division_prime_test.sv
// trial-division primality test, one candidate at a time
// after accept: a bound check; candidates below 4 need no trial factor and go straight to the result
// otherwise each factor tried costs one bound check, VALUE_W radix-2 remainder steps and one test
// a factor that divides marks the candidate composite; a failed bound check ends the search as prime
// throughput: a request is taken only after the last result is loaded, which out_stall can delay
// worst case for 32-bit candidates 65534 factors; reset: rst_n clears the state and out_valid
`timescale 1ns / 1ps

module trial_division_prime_test import tdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_candidate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_tested_value,
  output logic               out_is_prime
);

  tdp_cmd_t  cmd;
  tdp_stat_t stat;

  // sequencer
  tdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // factor, remainder and output registers
  tdp_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_candidate     (in_candidate),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tested_value (out_tested_value),
    .out_is_prime     (out_is_prime)
  );

endmodule

FILE: rtl/core/tdp_checker.sv
`timescale 1ns / 1ps

module tdp_checker import tdp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [VALUE_W-1:0] out_tested_value,
  input logic               out_is_prime
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tested_value)
      && $stable(out_is_prime))
    else $error("stalled result changed");

  // one request in flight: input stalls right after a request is taken
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // zero and one are never prime
  a_below_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tested_value < VALUE_W'(2)) |-> !out_is_prime)
    else $error("value below two reported prime");

  // even values other than two are composite
  a_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tested_value[0] && (out_tested_value != VALUE_W'(2))
      |-> !out_is_prime)
    else $error("even value reported prime");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (.*);

FILE: tb/tb_trial_division_prime_test.sv
`timescale 1ns / 1ps

module tb_trial_division_prime_test;
  import tdp_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 50;
  localparam int N_RANDOM        = 85;
  localparam int N_PROBES        = 17;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               prime;
  } verdict_t;

  // directed request with its verdict where it is obvious
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               known;
    logic               prime;
  } probe_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] in_candidate;
  logic               out_valid;
  logic               out_stall;
  logic [VALUE_W-1:0] out_tested_value;
  logic               out_is_prime;

  verdict_t verdict_q[$];
  int       errors;
  int       quiet_cycles;
  bit       steady;
  bit       hold_req;

  probe_t probes [N_PROBES] = '{
    '{32'd0,          1'b1, 1'b0},
    '{32'd1,          1'b1, 1'b0},
    '{32'd2,          1'b1, 1'b1},
    '{32'd3,          1'b0, 1'b0},
    '{32'd4,          1'b0, 1'b0},
    '{32'd5,          1'b0, 1'b0},
    '{32'd9,          1'b0, 1'b0},
    '{32'd25,         1'b0, 1'b0},
    '{32'd49,         1'b0, 1'b0},
    '{32'd63001,      1'b0, 1'b0},
    '{32'd65521,      1'b0, 1'b0},
    '{32'd65535,      1'b0, 1'b0},
    '{32'd1000003,    1'b0, 1'b0},
    '{32'hFFFF_FFFF,  1'b1, 1'b0},
    '{32'hFFFF_FFFE,  1'b1, 1'b0},
    '{32'h8000_0000,  1'b1, 1'b0},
    '{32'd4294836225, 1'b0, 1'b0}
  };

  trial_division_prime_test dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tested_value (out_tested_value),
    .out_is_prime     (out_is_prime)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // trial division up to the square root of the candidate
  function automatic bit division_finds_prime(input logic [VALUE_W-1:0] n);
    longint unsigned num;
    longint unsigned f;
    num = 64'(n);
    if (num < 2) return 1'b0;
    for (f = 2; f <= num / f; f++)
      if (num % f == 0) return 1'b0;
    return 1'b1;
  endfunction

  // mostly small candidates; wide ones carry a small factor to keep runs short
  function automatic logic [VALUE_W-1:0] pick_candidate();
    int                 r;
    logic [VALUE_W-1:0] x;
    logic [VALUE_W-1:0] p;
    r = $urandom_range(0, 99);
    if (r < 65) return VALUE_W'($urandom_range(0, 4095));
    if (r < 80) return VALUE_W'($urandom_range(4096, 65535));
    x = VALUE_W'($urandom);
    case ($urandom_range(0, 3))
      0: p = VALUE_W'(2);
      1: p = VALUE_W'(3);
      2: p = VALUE_W'(5);
      default: p = VALUE_W'(7);
    endcase
    return x - (x % p);
  endfunction

  // offer one request and record its verdict once taken
  task automatic offer(input logic [VALUE_W-1:0] c, input bit known, input bit prime);
    verdict_t v;
    int       gap;
    in_valid     <= 1'b1;
    in_candidate <= c;
    do @(posedge clk); while (in_stall);
    v.value = c;
    v.prime = known ? prime : division_finds_prime(c);
    verdict_q = {verdict_q, v};
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int w;
    out_stall = 1'b1;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        w = steady ? 0 : $urandom_range(0, 4);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected result: value %0d is_prime %0b", out_tested_value,
                   out_is_prime);
        errors++;
      end else begin
        v = verdict_q.pop_front();
        if (out_tested_value !== v.value || out_is_prime !== v.prime) begin
          if (errors < MAX_REPORTS)
            $display("mismatch: expected value %0d is_prime %0b, got value %0d is_prime %0b",
                     v.value, v.prime, out_tested_value, out_is_prime);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_candidate = '0;
    errors       = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests
    for (int i = 0; i < N_PROBES; i++)
      offer(probes[i].value, probes[i].known, probes[i].prime);

    // random requests with a back-to-back stretch under a long result hold
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 30) begin
        steady   = 1'b1;
        hold_req = 1'b1;
      end
      if (i == 45) steady = 1'b0;
      if (i == 60) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      offer(pick_candidate(), 1'b0, 1'b0);
    end
    in_valid <= 1'b0;

    // drain
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
